/* hdl/lkvc_pkg.sv */
package lkvc_pkg;

    localparam int ENTRIES_DEF    = 8;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 64;

    localparam int             ACTIVE_W     = 4;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_STORE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_TOUCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear_idx;
        logic scan;
        logic decide;
        logic touch;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;
        logic touch_needed;
        logic out_free;
    } t_dp_status;

endpackage

/* hdl/lkvc_ram.sv */
module lkvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lkvc_ctrl.sv */
module lkvc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    output lkvc_pkg::t_dp_cmd     o_cmd,
    input  lkvc_pkg::t_dp_status  i_status
);
    import lkvc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture   = 1'b1;
                    o_cmd.clear_idx = 1'b1;
                    n_state         = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.idx_last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide    = 1'b1;
                o_cmd.clear_idx = 1'b1;
                n_state         = i_status.touch_needed ? ST_TOUCH : ST_DONE;
            end
            ST_TOUCH: begin
                o_cmd.touch = 1'b1;
                if (i_status.idx_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* hdl/lkvc_datapath.sv */
module lkvc_datapath #(
    parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lkvc_pkg::t_dp_cmd             i_cmd,
    output lkvc_pkg::t_dp_status          o_status,
    input  logic                          i_req_cmd,
    input  logic [KEY_BITS-1:0]           i_req_key,
    input  logic [VALUE_BITS-1:0]         i_req_value,
    input  logic                          i_cfg_we,
    input  logic [lkvc_pkg::ACTIVE_W-1:0] i_cfg_wdata,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_out_hit,
    output logic [VALUE_BITS-1:0]         o_out_value
);
    import lkvc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int AGE_W = IDX_W;
    localparam int LIM_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

    logic [ACTIVE_W-1:0]   r_active;
    logic [ENTRIES-1:0]    r_valid;
    logic                  r_req_cmd;
    logic [KEY_BITS-1:0]   r_req_key;
    logic [VALUE_BITS-1:0] r_req_value;

    logic [CNT_W-1:0] r_idx;
    logic             r_pipe_vld;
    logic [IDX_W-1:0] r_pipe_idx;
    logic             idx_last;

    logic [CNT_W-1:0] r_count;
    logic             r_found;
    logic [IDX_W-1:0] r_match;
    logic [AGE_W-1:0] r_match_age;
    logic             r_have_old;
    logic [IDX_W-1:0] r_oldest;
    logic [AGE_W-1:0] r_oldest_age;
    logic             r_have_free;
    logic [IDX_W-1:0] r_free;

    logic [IDX_W-1:0] r_slot;
    logic [AGE_W-1:0] r_old_age;
    logic             r_touch_all;
    logic             r_res_read;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [VALUE_BITS-1:0] r_out_value;

    logic [KEY_BITS-1:0]   key_rd;
    logic [VALUE_BITS-1:0] val_rd;
    logic [AGE_W-1:0]      age_rd;

    logic [LIM_W-1:0] act_ext;
    logic [LIM_W-1:0] limit;
    logic             evict;
    logic             have_slot;
    logic [IDX_W-1:0] new_slot;
    logic             insert;
    logic             touch_needed;

    logic             age_we;
    logic [AGE_W-1:0] age_wdata;
    logic             pipe_step;

    assign idx_last  = (r_idx == CNT_W'(ENTRIES));
    assign pipe_step = (i_cmd.scan || i_cmd.touch) && !idx_last;

    always_comb begin
        act_ext = LIM_W'(r_active);
        if (act_ext == '0) begin
            limit = LIM_W'(1);
        end else if (act_ext > LIM_W'(ENTRIES)) begin
            limit = LIM_W'(ENTRIES);
        end else begin
            limit = act_ext;
        end
        evict        = (r_req_cmd == CMD_STORE) && !r_found
                       && (LIM_W'(r_count) >= limit) && r_have_old;
        have_slot    = evict || r_have_free;
        new_slot     = evict ? r_oldest : r_free;
        insert       = (r_req_cmd == CMD_STORE) && !r_found && have_slot;
        touch_needed = r_found || insert;
    end

    always_comb begin
        age_we    = 1'b0;
        age_wdata = '0;
        if (i_cmd.touch && r_pipe_vld) begin
            if (r_pipe_idx == r_slot) begin
                age_we = 1'b1;
            end else if (r_valid[r_pipe_idx] && (r_touch_all || age_rd < r_old_age)) begin
                age_we    = 1'b1;
                age_wdata = age_rd + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= ACTIVE_RESET;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (i_cmd.decide && insert) begin
                r_valid[new_slot] <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_cmd   <= i_req_cmd;
            r_req_key   <= i_req_key;
            r_req_value <= i_req_value;
        end

        if (i_cmd.clear_idx) begin
            r_idx <= '0;
        end else if (pipe_step) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        r_pipe_vld <= pipe_step;
        r_pipe_idx <= r_idx[IDX_W-1:0];

        if (i_cmd.capture) begin
            r_count     <= '0;
            r_found     <= 1'b0;
            r_have_old  <= 1'b0;
            r_have_free <= 1'b0;
        end else if (i_cmd.scan && r_pipe_vld) begin
            if (r_valid[r_pipe_idx]) begin
                r_count <= r_count + CNT_W'(1);
                if (!r_found && key_rd == r_req_key) begin
                    r_found     <= 1'b1;
                    r_match     <= r_pipe_idx;
                    r_match_age <= age_rd;
                end
                if (!r_have_old || age_rd > r_oldest_age) begin
                    r_have_old   <= 1'b1;
                    r_oldest     <= r_pipe_idx;
                    r_oldest_age <= age_rd;
                end
            end else if (!r_have_free) begin
                r_have_free <= 1'b1;
                r_free      <= r_pipe_idx;
            end
        end

        if (i_cmd.decide) begin
            r_slot      <= r_found ? r_match : new_slot;
            r_old_age   <= r_match_age;
            r_touch_all <= !r_found;
            r_res_read  <= (r_req_cmd == CMD_LOOKUP) && r_found;
        end

        if (i_cmd.load_out) begin
            r_out_hit   <= r_found;
            r_out_value <= r_res_read ? val_rd : '0;
        end
    end

    lkvc_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.decide && insert),
        .i_waddr (new_slot),
        .i_wdata (r_req_key),
        .i_re    (i_cmd.scan && !idx_last),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (key_rd)
    );

    lkvc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.decide && (r_req_cmd == CMD_STORE) && (r_found || have_slot)),
        .i_waddr (r_found ? r_match : new_slot),
        .i_wdata (r_req_value),
        .i_re    (i_cmd.decide && (r_req_cmd == CMD_LOOKUP) && r_found),
        .i_raddr (r_match),
        .o_rdata (val_rd)
    );

    lkvc_ram #(
        .WIDTH (AGE_W),
        .DEPTH (ENTRIES)
    ) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (age_we),
        .i_waddr (r_pipe_idx),
        .i_wdata (age_wdata),
        .i_re    (pipe_step),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (age_rd)
    );

    assign o_status.idx_last     = idx_last;
    assign o_status.touch_needed = touch_needed;
    assign o_status.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_hit   = r_out_hit;
    assign o_out_value = r_out_value;

endmodule

/* hdl/lru_key_value_cache_top.sv */
// Fully associative key/value cache with least-recently-used replacement.
// Requests arrive on the s_axis channel: tuser is the command (0 lookup,
// 1 store) and tdata carries the key in the low bits with the value above.
// Each request gives exactly one response on the m_axis channel: tuser is
// the hit flag and tdata the stored value on a lookup hit, zero otherwise.
// A request is accepted, then the key and age memories are scanned
// serially, a decision is made, an age update pass runs when an entry
// is hit or inserted, and the output register is loaded. A lookup miss
// skips the age update pass. Both passes read one entry per cycle.
// One request is worked on at a time; the next is accepted once the
// response sits in the output register, even if it has not been taken.
// If the receiver stalls, the response is held and the request in progress
// waits in its final state until the output register is free.
// Reset clears all valid bits and sets the active entry limit to eight;
// no clearing pass is needed. The limit is written through i_cfg_we and
// i_cfg_wdata; the user must do so while the block is idle (not enforced).
module lru_key_value_cache_top #(
    parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF,
    parameter int S_DATA_W   = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    parameter int M_DATA_W   = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [S_DATA_W-1:0]           s_axis_tdata,  // lookup_key, write_value
    input  logic                          s_axis_tuser,  // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [M_DATA_W-1:0]           m_axis_tdata,  // read_value
    output logic                          m_axis_tuser,  // hit
    input  logic                          i_cfg_we,
    input  logic [lkvc_pkg::ACTIVE_W-1:0] i_cfg_wdata
);
    import lkvc_pkg::*;

    t_dp_cmd               dp_cmd;
    t_dp_status            dp_status;
    logic [VALUE_BITS-1:0] out_value;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    lkvc_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_req_cmd   (s_axis_tuser),
        .i_req_key   (s_axis_tdata[KEY_BITS-1:0]),
        .i_req_value (s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_hit   (m_axis_tuser),
        .o_out_value (out_value)
    );

    assign m_axis_tdata = M_DATA_W'(out_value);

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |=> m_axis_tvalid)
        else $error("response not presented after load");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |-> dp_status.out_free)
        else $error("pending response overwritten");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("miss response carries data");

    a_ready_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && (dp_cmd.load_out || dp_cmd.scan || dp_cmd.touch)))
        else $error("request accepted while busy");

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    localparam int ENTRIES    = ENTRIES_DEF;
    localparam int KEY_BITS   = KEY_BITS_DEF;
    localparam int VALUE_BITS = VALUE_BITS_DEF;
    localparam int S_DATA_W   = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = ((VALUE_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4 * ENTRIES + 20;
    localparam logic [KEY_BITS-1:0]   KEY_ONES   = '1;
    localparam logic [VALUE_BITS-1:0] VALUE_ONES = '1;

    typedef struct packed {
        logic                  cmd;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_cache_req;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
    } t_cache_reply;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;  // lookup_key, write_value
    logic                  s_axis_tuser  = 1'b0; // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;        // read_value
    logic                  m_axis_tuser;        // hit
    logic                  i_cfg_we      = 1'b0;
    logic [ACTIVE_W-1:0]   i_cfg_wdata   = '0;

    t_cache_req   request_queue[$];
    t_cache_reply expected_replies[$];
    t_cache_req   req_in_flight;
    t_cache_reply reply_due;

    logic                    model_valid [ENTRIES];
    logic [KEY_BITS-1:0]     model_key   [ENTRIES];
    logic [VALUE_BITS-1:0]   model_value [ENTRIES];
    int unsigned             model_age   [ENTRIES];
    logic [ACTIVE_W-1:0]     model_limit = ACTIVE_RESET;

    int  mismatches  = 0;
    int  cycles      = 0;
    int  send_gap    = 0;
    int  recv_stall  = 0;
    bit  quiet       = 1'b0;

    lru_key_value_cache_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            model_valid[i] = 1'b0;
            model_key[i]   = '0;
            model_value[i] = '0;
            model_age[i]   = 0;
        end
    end

    function automatic void age_entries(input int slot, input int unsigned old_age);
        for (int i = 0; i < ENTRIES; i++) begin
            if (model_valid[i] && i != slot && model_age[i] < old_age) begin
                model_age[i]++;
            end
        end
        model_age[slot] = 0;
    endfunction

    function automatic t_cache_reply lru_access(input t_cache_req rq);
        t_cache_reply rs;
        int           occupied;
        int           match;
        int           oldest;
        int           free_slot;
        int unsigned  oldest_age;
        int           limit;
        bit           found;
        bit           have_old;
        bit           have_free;
        occupied   = 0;
        match      = 0;
        oldest     = 0;
        free_slot  = 0;
        oldest_age = 0;
        found      = 1'b0;
        have_old   = 1'b0;
        have_free  = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (model_valid[i]) begin
                occupied++;
                if (!found && model_key[i] == rq.key) begin
                    found = 1'b1;
                    match = i;
                end
                if (!have_old || model_age[i] > oldest_age) begin
                    have_old   = 1'b1;
                    oldest     = i;
                    oldest_age = model_age[i];
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_slot = i;
            end
        end
        rs.hit        = found;
        rs.read_value = '0;
        limit = (model_limit == 0) ? 1 : (model_limit > ENTRIES) ? ENTRIES : model_limit;
        if (rq.cmd == CMD_LOOKUP) begin
            if (found) begin
                rs.read_value = model_value[match];
                age_entries(match, model_age[match]);
            end
        end else if (found) begin
            model_value[match] = rq.value;
            age_entries(match, model_age[match]);
        end else begin
            if (occupied >= limit && have_old) begin
                model_valid[oldest] = 1'b0;
                free_slot = oldest;
                have_free = 1'b1;
            end
            if (have_free) begin
                age_entries(free_slot, 32'hFFFF_FFFF);
                model_valid[free_slot] = 1'b1;
                model_key[free_slot]   = rq.key;
                model_value[free_slot] = rq.value;
            end
        end
        return rs;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_replies.push_back(lru_access(req_in_flight));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (!quiet && request_queue.size() != 0
                             && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 5) - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    req_in_flight = request_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {req_in_flight.value, req_in_flight.key};
                    s_axis_tuser  <= req_in_flight.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_replies.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected reply: hit=%0b value=%h", m_axis_tuser, m_axis_tdata);
                end
                mismatches++;
            end else begin
                reply_due = expected_replies.pop_front();
                if (m_axis_tuser !== reply_due.hit || m_axis_tdata !== reply_due.read_value) begin
                    if (mismatches < 10) begin
                        $display("reply error: hit exp %0b got %0b, value exp %h got %h",
                                 reply_due.hit, m_axis_tuser,
                                 reply_due.read_value, m_axis_tdata);
                    end
                    mismatches++;
                end
            end
        end
        if (recv_stall > 0) begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            recv_stall = $urandom_range(1, 5) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("lru_key_value_cache_top: mismatch");
            $finish;
        end
    end

    task automatic push_request(input logic cmd, input logic [KEY_BITS-1:0] key,
                                input logic [VALUE_BITS-1:0] value);
        t_cache_req rq;
        rq.cmd   = cmd;
        rq.key   = key;
        rq.value = value;
        request_queue.push_back(rq);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (request_queue.size() != 0 || s_axis_tvalid || expected_replies.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_limit(input logic [ACTIVE_W-1:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        model_limit = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [VALUE_BITS-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return VALUE_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    logic [ACTIVE_W-1:0] phase_limits[11] = '{1, 2, 8, 3, 0, 5, 15, 4, 7, 6, 8};
    logic [KEY_BITS-1:0] key_pool[12];
    logic [KEY_BITS-1:0] pick_key;

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset limit: empty misses, extremes, replacement,
        // filling to the limit and evicting the least recent entry.
        push_request(CMD_LOOKUP, '0, VALUE_ONES);
        push_request(CMD_STORE, '0, '0);
        push_request(CMD_STORE, KEY_ONES, VALUE_ONES);
        push_request(CMD_LOOKUP, '0, '0);
        push_request(CMD_LOOKUP, KEY_ONES, '0);
        push_request(CMD_STORE, '0, 64'hA5A5_5A5A_C3C3_3C3C);
        push_request(CMD_LOOKUP, '0, '0);
        for (int k = 1; k <= 6; k++) begin
            push_request(CMD_STORE, KEY_BITS'(k), {$urandom, $urandom});
        end
        push_request(CMD_LOOKUP, 32'h1234_5678, '0);
        push_request(CMD_STORE, 32'd7, 64'h0123_4567_89AB_CDEF);
        push_request(CMD_LOOKUP, KEY_ONES, '0);
        push_request(CMD_LOOKUP, 32'd1, '0);
        push_request(CMD_STORE, 32'd8, random_value());

        // A zero limit acts as one, and lies below the current occupancy.
        write_limit(4'd0);
        push_request(CMD_STORE, 32'd9, random_value());
        push_request(CMD_STORE, 32'd10, random_value());
        push_request(CMD_LOOKUP, 32'd9, '0);
        push_request(CMD_LOOKUP, 32'd10, '0);

        // A limit above the entry count acts as the full size.
        write_limit(4'd15);
        push_request(CMD_STORE, 32'h8000_0000, random_value());
        push_request(CMD_LOOKUP, 32'd2, '0);
        push_request(CMD_STORE, 32'h0000_0001, VALUE_ONES);

        foreach (phase_limits[p]) begin
            write_limit(phase_limits[p]);
            if (p == $size(phase_limits) - 1) begin
                quiet = 1'b1;
            end
            foreach (key_pool[k]) begin
                case ($urandom_range(0, 9))
                    0:       key_pool[k] = '0;
                    1:       key_pool[k] = KEY_ONES;
                    default: key_pool[k] = $urandom;
                endcase
            end
            repeat (75) begin
                if ($urandom_range(0, 99) < 85) begin
                    pick_key = key_pool[$urandom_range(0, 11)];
                end else begin
                    pick_key = $urandom;
                end
                push_request($urandom_range(0, 1) ? CMD_STORE : CMD_LOOKUP,
                             pick_key, random_value());
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("lru_key_value_cache_top: match");
        end else begin
            $display("lru_key_value_cache_top: mismatch");
        end
        $finish;
    end

endmodule

/* lru_key_value_cache_top.f */
hdl/lkvc_pkg.sv
hdl/lkvc_ram.sv
hdl/lkvc_ctrl.sv
hdl/lkvc_datapath.sv
hdl/lru_key_value_cache_top.sv
tb/tb_top.sv
